FILE: src/priority_collection_table_assert.svh
// assertion macros for the priority collection table
`ifndef PRIORITY_COLLECTION_TABLE_ASSERT_SVH
`define PRIORITY_COLLECTION_TABLE_ASSERT_SVH

// same-cycle implication
`define PCT_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pct assertion failed");

// next-cycle implication
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pct assertion failed");

`endif

FILE: src/pct_pkg.sv
`default_nettype none
package pct_pkg;

   localparam int unsigned DEF_ENTRIES        = 64;
   localparam int unsigned DEF_PRIORITY_WIDTH = 16;
   localparam int unsigned DEF_DATA_WIDTH     = 32;

   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned ID_W     = 6;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned PRIO_W   = 16;
   localparam int unsigned SEQ_W    = 32;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      F_ADD     = 3'd0,
      F_PROMOTE = 3'd1,
      F_POP     = 3'd2,
      F_PEEK    = 3'd3,
      F_LOOKUP  = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_BAD_ID  = 2'd3
   } status_type;

   typedef struct packed {
      logic     active;
      func_type func;
      logic     id_ok;
      logic     add_blocked;
      logic     best_valid;
   } tok_ctrl_type;

endpackage
`default_nettype wire

FILE: src/pct_cell.sv
`default_nettype none
module pct_cell
   import pct_pkg::*;
#(
   parameter int unsigned ENTRIES        = DEF_ENTRIES,
   parameter int unsigned PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
   parameter int unsigned DATA_WIDTH     = DEF_DATA_WIDTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [$clog2(ENTRIES)-1:0] cell_index,
   input  wire tok_ctrl_type               ctrl_in,
   input  wire logic [$clog2(ENTRIES)-1:0] id_in,
   input  wire logic [$clog2(ENTRIES)-1:0] best_slot_in,
   input  wire logic [PRIORITY_WIDTH-1:0]  best_prio_in,
   input  wire logic [SEQ_W-1:0]           best_seq_in,
   input  wire logic [DATA_WIDTH-1:0]      best_data_in,
   input  wire logic                       clr_en,
   input  wire logic [$clog2(ENTRIES)-1:0] clr_slot,
   output tok_ctrl_type                    ctrl_out,
   output logic [$clog2(ENTRIES)-1:0]      id_out,
   output logic [$clog2(ENTRIES)-1:0]      best_slot_out,
   output logic [PRIORITY_WIDTH-1:0]       best_prio_out,
   output logic [SEQ_W-1:0]                best_seq_out,
   output logic [DATA_WIDTH-1:0]           best_data_out
);

   localparam int unsigned IDW = $clog2(ENTRIES);

   tok_ctrl_type              ctrl_ff, ctrl_in_n;
   logic [IDW-1:0]            id_ff;
   logic [IDW-1:0]            slot_ff, slot_in;
   logic [PRIORITY_WIDTH-1:0] bprio_ff, bprio_in;
   logic [SEQ_W-1:0]          bseq_ff, bseq_in;
   logic [DATA_WIDTH-1:0]     bdata_ff, bdata_in;

   logic                      valid_ff, valid_in;
   logic [PRIORITY_WIDTH-1:0] prio_ff, prio_in;
   logic [SEQ_W-1:0]          seq_ff, seq_in;
   logic [DATA_WIDTH-1:0]     data_ff, data_in;

   logic                      hit;
   logic                      better;
   logic [PRIORITY_WIDTH-1:0] prio_up;

   assign hit     = ctrl_in.id_ok && (id_in == cell_index) && valid_ff;
   assign better  = !ctrl_in.best_valid || (prio_ff > best_prio_in) ||
                    ((prio_ff == best_prio_in) && (seq_ff > best_seq_in));
   assign prio_up = (prio_ff == '1) ? prio_ff : prio_ff + 1'b1;

   always_comb begin
      ctrl_in_n = ctrl_in;
      slot_in   = best_slot_in;
      bprio_in  = best_prio_in;
      bseq_in   = best_seq_in;
      bdata_in  = best_data_in;
      valid_in  = valid_ff;
      prio_in   = prio_ff;
      seq_in    = seq_ff;
      data_in   = data_ff;
      if (ctrl_in.active) begin
         case (ctrl_in.func)
            F_ADD: begin
               if (!ctrl_in.add_blocked && !ctrl_in.best_valid && !valid_ff) begin
                  valid_in             = 1'b1;
                  prio_in              = '0;
                  seq_in               = best_seq_in;
                  data_in              = best_data_in;
                  ctrl_in_n.best_valid = 1'b1;
                  slot_in              = cell_index;
               end
            end
            F_PROMOTE, F_LOOKUP: begin
               if (hit) begin
                  if (ctrl_in.func == F_PROMOTE) begin
                     prio_in = prio_up;
                  end
                  ctrl_in_n.best_valid = 1'b1;
                  slot_in              = cell_index;
                  bprio_in             = (ctrl_in.func == F_PROMOTE) ? prio_up : prio_ff;
                  bdata_in             = data_ff;
               end
            end
            F_POP, F_PEEK: begin
               if (valid_ff && better) begin
                  ctrl_in_n.best_valid = 1'b1;
                  slot_in              = cell_index;
                  bprio_in             = prio_ff;
                  bseq_in              = seq_ff;
                  bdata_in             = data_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (clr_en && (clr_slot == cell_index)) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         ctrl_ff  <= ctrl_in_n;
         valid_ff <= valid_in;
      end
      id_ff    <= id_in;
      slot_ff  <= slot_in;
      bprio_ff <= bprio_in;
      bseq_ff  <= bseq_in;
      bdata_ff <= bdata_in;
      prio_ff  <= prio_in;
      seq_ff   <= seq_in;
      data_ff  <= data_in;
   end

   assign ctrl_out      = ctrl_ff;
   assign id_out        = id_ff;
   assign best_slot_out = slot_ff;
   assign best_prio_out = bprio_ff;
   assign best_seq_out  = bseq_ff;
   assign best_data_out = bdata_ff;

endmodule
`default_nettype wire

FILE: src/priority_collection_table.sv
// priority collection table
// req channel: req_valid/req_stall with func, entry_id and data_value; one
// transfer is one operation (add, promote, pop max, peek max, lookup by id).
// rsp channel: rsp_valid/rsp_stall with status, slot_id, value_out,
// priority_out and found; every operation gives exactly one rsp transfer.
// the table is a chain of ENTRIES cells, each owning one slot; an operation
// travels the chain as a token, one cell per cycle, so every operation scans
// all slots. the result is registered when the token leaves the last cell,
// and a new req can be taken once the result is registered; one operation
// is in flight at a time. req_stall is high while an operation travels the
// chain and while a result waits under rsp_stall; a stalled result holds its
// value. reset empties the table and restarts the sequence count; no sweep
// is needed after reset.
`default_nettype none
`include "priority_collection_table_assert.svh"
module priority_collection_table
   import pct_pkg::*;
#(
   parameter int unsigned ENTRIES        = DEF_ENTRIES,
   parameter int unsigned PRIORITY_WIDTH = DEF_PRIORITY_WIDTH,
   parameter int unsigned DATA_WIDTH     = DEF_DATA_WIDTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [FUNC_W-1:0]   req_func,
   input  wire logic [ID_W-1:0]     req_entry_id,
   input  wire logic [VALUE_W-1:0]  req_data_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [ID_W-1:0]          rsp_slot_id,
   output logic [VALUE_W-1:0]       rsp_value_out,
   output logic [PRIO_W-1:0]        rsp_priority_out,
   output logic                     rsp_found
);

   localparam int unsigned IDW = $clog2(ENTRIES);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [SEQ_W-1:0] next_seq_ff, next_seq_in;

   tok_ctrl_type              ctrl_c  [ENTRIES+1];
   logic [IDW-1:0]            id_c    [ENTRIES+1];
   logic [IDW-1:0]            slot_c  [ENTRIES+1];
   logic [PRIORITY_WIDTH-1:0] prio_c  [ENTRIES+1];
   logic [SEQ_W-1:0]          seq_c   [ENTRIES+1];
   logic [DATA_WIDTH-1:0]     data_c  [ENTRIES+1];
   logic [ENTRIES-1:0]        active_vec;

   logic accept;
   logic finish;
   logic clr_en;
   tok_ctrl_type last;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     slot_ff, slot_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [PRIO_W-1:0]   prio_ff, prio_in;
   logic                found_ff, found_in;

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign last      = ctrl_c[ENTRIES];
   assign finish    = last.active;
   assign clr_en    = finish && (last.func == F_POP) && last.best_valid;

   always_comb begin
      ctrl_c[0].active      = accept;
      ctrl_c[0].func        = func_type'(req_func);
      ctrl_c[0].id_ok       = 32'(req_entry_id) < ENTRIES;
      ctrl_c[0].add_blocked = next_seq_ff == '1;
      ctrl_c[0].best_valid  = 1'b0;
      id_c[0]               = IDW'(req_entry_id);
      slot_c[0]             = '0;
      prio_c[0]             = '0;
      seq_c[0]              = next_seq_ff + 1'b1;
      data_c[0]             = DATA_WIDTH'(req_data_value);
   end

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      pct_cell #(
         .ENTRIES        (ENTRIES),
         .PRIORITY_WIDTH (PRIORITY_WIDTH),
         .DATA_WIDTH     (DATA_WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .cell_index    (IDW'(i)),
         .ctrl_in       (ctrl_c[i]),
         .id_in         (id_c[i]),
         .best_slot_in  (slot_c[i]),
         .best_prio_in  (prio_c[i]),
         .best_seq_in   (seq_c[i]),
         .best_data_in  (data_c[i]),
         .clr_en        (clr_en),
         .clr_slot      (slot_c[ENTRIES]),
         .ctrl_out      (ctrl_c[i+1]),
         .id_out        (id_c[i+1]),
         .best_slot_out (slot_c[i+1]),
         .best_prio_out (prio_c[i+1]),
         .best_seq_out  (seq_c[i+1]),
         .best_data_out (data_c[i+1])
      );
      assign active_vec[i] = ctrl_c[i+1].active;
   end

   always_comb begin
      state_in     = state_ff;
      next_seq_in  = next_seq_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      prio_in      = prio_ff;
      found_in     = found_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_BUSY;
            end
         end
         S_BUSY: begin
            if (finish) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               status_in    = ST_OK;
               slot_in      = ID_W'(slot_c[ENTRIES]);
               value_in     = VALUE_W'(data_c[ENTRIES]);
               prio_in      = PRIO_W'(prio_c[ENTRIES]);
               found_in     = 1'b1;
               case (last.func)
                  F_ADD: begin
                     prio_in = '0;
                     if (last.add_blocked || !last.best_valid) begin
                        status_in = ST_FULL;
                     end else begin
                        next_seq_in = seq_c[ENTRIES];
                     end
                  end
                  F_PROMOTE, F_LOOKUP: begin
                     if (!last.id_ok || !last.best_valid) begin
                        status_in = ST_BAD_ID;
                     end
                  end
                  F_POP, F_PEEK: begin
                     if (!last.best_valid) begin
                        status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     found_in = 1'b0;
                  end
               endcase
               if (status_in != ST_OK || !found_in) begin
                  slot_in  = '0;
                  value_in = '0;
                  prio_in  = '0;
                  found_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         next_seq_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_seq_ff  <= next_seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      slot_ff   <= slot_in;
      value_ff  <= value_in;
      prio_ff   <= prio_in;
      found_ff  <= found_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_slot_id      = slot_ff;
   assign rsp_value_out    = value_ff;
   assign rsp_priority_out = prio_ff;
   assign rsp_found        = found_ff;

   `PCT_ASSERT_NOW(a_one_token, state_ff == S_BUSY, $onehot(active_vec))
   `PCT_ASSERT_NOW(a_idle_empty, state_ff == S_IDLE, active_vec == '0)
   `PCT_ASSERT_NEXT(a_finish_rsp, finish, rsp_valid_ff && state_ff == S_IDLE)
   `PCT_ASSERT_NOW(a_found_ok, rsp_valid_ff && rsp_found, rsp_status == ST_OK)

endmodule
`default_nettype wire
